FILE: design/sblr_pkg.sv
// Shared constants, types and codes of the separable bilinear line resampler.
// Depends on nothing; the interfaces, the top level and the checker import it.
`default_nettype none

package sblr_pkg;

   localparam int MAX_SOURCE    = 4096;
   localparam int MAX_DEST      = 1024;
   localparam int MAX_TAPS      = 16;
   localparam int FRACTION_BITS = 22;
   localparam int PIXEL_MAX     = 255;
   localparam int CHANNELS      = 3;

   // Field widths of the transactions and registers.
   localparam int MODE_W     = 2;
   localparam int POS_W      = 12;
   localparam int TAP_W      = 4;
   localparam int WEIGHT_W   = 24;
   localparam int COUNT_W    = 5;
   localparam int PIX_W      = 8;
   localparam int SRCLEN_W   = 13;
   localparam int DSTLEN_W   = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = SRCLEN_W;

   // Store geometry.
   localparam int SRC_AW   = $clog2(MAX_SOURCE);
   localparam int DEST_AW  = $clog2(MAX_DEST);
   localparam int TAP_AW   = $clog2(MAX_TAPS);
   localparam int WADDR_W  = DEST_AW + TAP_AW;
   localparam int RGB_W    = CHANNELS * PIX_W;
   localparam int BOUNDS_W = POS_W + COUNT_W;

   // Range compares are done at a width that holds every limit and sum.
   localparam int CMP_W = $clog2((MAX_SOURCE > MAX_DEST) ? MAX_SOURCE : MAX_DEST) + 2;

   // Accumulator: pixel times weight, grown by the tap count, plus sign.
   localparam int PROD_W = PIX_W + 1 + WEIGHT_W;
   localparam int ACC_W  = PROD_W + TAP_AW + 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_WEIGHT  = 2'd0,
      MODE_BOUNDS  = 2'd1,
      MODE_PIXEL   = 2'd2,
      MODE_COMPUTE = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_LENGTH = 1'b0,
      CSR_DEST_LENGTH   = 1'b1
   } csr_index_type;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_RANGE = 1'b1
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BOUNDS,
      ST_FETCH,
      ST_MAC,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: design/sblr_if.sv
// Handshake interfaces of the resampler: request and response channels.
// Depends on sblr_pkg for the field widths.
`default_nettype none

interface sblr_req_if;
   import sblr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [POS_W-1:0]           position;
   logic [TAP_W-1:0]           tap;
   logic signed [WEIGHT_W-1:0] weight;
   logic [POS_W-1:0]           first_source;
   logic [COUNT_W-1:0]         tap_count;
   logic [PIX_W-1:0]           red_in;
   logic [PIX_W-1:0]           green_in;
   logic [PIX_W-1:0]           blue_in;

   modport source (output valid, mode, position, tap, weight, first_source, tap_count,
                   red_in, green_in, blue_in, input ready);
   modport sink   (input valid, mode, position, tap, weight, first_source, tap_count,
                   red_in, green_in, blue_in, output ready);
endinterface

interface sblr_rsp_if;
   import sblr_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_out;
   logic [PIX_W-1:0] green_out;
   logic [PIX_W-1:0] blue_out;
   logic             status;

   modport source (output valid, red_out, green_out, blue_out, status, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

`default_nettype wire

FILE: design/sblr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the weight, bounds and line stores.
`default_nettype none

module sblr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/separable_bilinear_line_resampler.sv
// Top level of the separable bilinear line resampler: stores, sequencer and MAC.
// Depends on sblr_pkg, sblr_if (sblr_req_if, sblr_rsp_if) and sblr_ram.
//
//   channel   direction  handshake            carries
//   req_chan  in         valid/ready          mode, position, tap, weight, bounds, pixel
//   rsp_chan  out        valid/ready          red_out, green_out, blue_out, status
//   csr_*     in         csr_we only          source_length, dest_length
//
// A load transaction (weight, bounds or pixel) is taken and the block stays ready.
// A compute transaction runs in steps before its result is registered: one
// bounds read, then per tap one store read and three passes of the single 9x24 multiplier,
// one per colour channel. Out-of-range requests go to the finish state from idle or bounds.
// Reset is synchronous; the stores are not cleared. The result register holds while rsp_chan
// is stalled, and load transactions are still taken meanwhile.
`default_nettype none

module separable_bilinear_line_resampler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   sblr_req_if.sink                           req_chan,
   sblr_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [sblr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sblr_pkg::CSR_DATA_W-1:0] csr_data
);
   import sblr_pkg::*;

   state_type state_ff, state_in;

   logic [SRCLEN_W-1:0] source_length_ff, source_length_in;
   logic [DSTLEN_W-1:0] dest_length_ff, dest_length_in;

   logic [DEST_AW-1:0] pos_ff, pos_in;
   logic [SRC_AW-1:0]  src_ff, src_in;
   logic [COUNT_W-1:0] tap_ff, tap_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         chan_ff, chan_in;
   logic               err_ff, err_in;

   logic signed [ACC_W-1:0] acc_ff [CHANNELS];
   logic signed [ACC_W-1:0] acc_in [CHANNELS];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] red_ff, red_in_r, green_ff, green_in_r, blue_ff, blue_in_r;
   logic             status_ff, status_in;

   logic             accept;
   mode_type         req_mode;
   logic [CMP_W-1:0] req_pos_wide;
   logic             pos_in_dest;
   logic             compute_bad;
   logic             rsp_free;
   logic             last_chan;
   logic             last_tap;

   logic [WEIGHT_W-1:0] weight_rd;
   logic [BOUNDS_W-1:0] bounds_rd;
   logic [RGB_W-1:0]    line_rd;

   logic [POS_W-1:0]   bound_first;
   logic [COUNT_W-1:0] bound_count;
   logic [CMP_W-1:0]   bound_end;
   logic               bounds_bad;

   logic [PIX_W-1:0]             pixel;
   logic signed [PROD_W-1:0]     product;
   logic signed [ACC_W-1:0]      acc_sum;
   logic                         finish_now;

   // ------------------------------------------------------------------ stores

   assign accept       = req_chan.valid && req_chan.ready;
   assign req_mode     = mode_type'(req_chan.mode);
   assign req_pos_wide = CMP_W'(req_chan.position);
   assign pos_in_dest  = req_pos_wide < CMP_W'(MAX_DEST);

   sblr_ram #(.WIDTH(WEIGHT_W), .DEPTH(2 ** WADDR_W)) u_weight_store (
      .clock   (clock),
      .wr_en   (accept && req_mode == MODE_WEIGHT && pos_in_dest &&
                CMP_W'(req_chan.tap) < CMP_W'(MAX_TAPS)),
      .wr_addr ({req_chan.position[DEST_AW-1:0], req_chan.tap[TAP_AW-1:0]}),
      .wr_data (req_chan.weight),
      .rd_addr ({pos_ff, tap_ff[TAP_AW-1:0]}),
      .rd_data (weight_rd)
   );

   sblr_ram #(.WIDTH(BOUNDS_W), .DEPTH(MAX_DEST)) u_bounds_store (
      .clock   (clock),
      .wr_en   (accept && req_mode == MODE_BOUNDS && pos_in_dest),
      .wr_addr (req_chan.position[DEST_AW-1:0]),
      .wr_data ({req_chan.tap_count, req_chan.first_source}),
      .rd_addr (req_chan.position[DEST_AW-1:0]),
      .rd_data (bounds_rd)
   );

   sblr_ram #(.WIDTH(RGB_W), .DEPTH(MAX_SOURCE)) u_line_store (
      .clock   (clock),
      .wr_en   (accept && req_mode == MODE_PIXEL && req_pos_wide < CMP_W'(MAX_SOURCE)),
      .wr_addr (req_chan.position[SRC_AW-1:0]),
      .wr_data ({req_chan.red_in, req_chan.green_in, req_chan.blue_in}),
      .rd_addr (src_ff),
      .rd_data (line_rd)
   );

   // --------------------------------------------------------- shared datapath

   assign compute_bad = (req_pos_wide >= CMP_W'(dest_length_ff)) || !pos_in_dest;

   assign bound_first = bounds_rd[POS_W-1:0];
   assign bound_count = bounds_rd[BOUNDS_W-1:POS_W];
   assign bound_end   = CMP_W'(bound_first) + CMP_W'(bound_count);
   assign bounds_bad  = (CMP_W'(bound_count) > CMP_W'(MAX_TAPS)) ||
                        (bound_end > CMP_W'(source_length_ff)) ||
                        (bound_end > CMP_W'(MAX_SOURCE));

   always_comb begin
      case (chan_ff)
         2'd0:    pixel = line_rd[RGB_W-1 -: PIX_W];
         2'd1:    pixel = line_rd[RGB_W-PIX_W-1 -: PIX_W];
         default: pixel = line_rd[PIX_W-1:0];
      endcase
   end

   // The accumulators rotate, so the multiplier always adds into acc_ff[0].
   assign product = $signed({1'b0, pixel}) * $signed(weight_rd);
   assign acc_sum = acc_ff[0] + ACC_W'(product);

   assign last_chan  = chan_ff == 2'(CHANNELS - 1);
   assign last_tap   = tap_ff == count_ff - COUNT_W'(1);
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign finish_now = (state_ff == ST_FINISH) && rsp_free;

   function automatic logic [PIX_W-1:0] clip_channel(input logic signed [ACC_W-1:0] sum);
      logic [ACC_W-FRACTION_BITS-1:0] whole;
      logic [PIX_W-1:0]               result;
      whole = sum[ACC_W-1:FRACTION_BITS];
      if (sum < 0) begin
         result = '0;
      end else if (whole > (ACC_W - FRACTION_BITS)'(PIXEL_MAX)) begin
         result = PIX_W'(PIXEL_MAX);
      end else begin
         result = whole[PIX_W-1:0];
      end
      return result;
   endfunction

   // ------------------------------------------------------------- sequencer

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_COMPUTE) begin
               state_in = compute_bad ? ST_FINISH : ST_BOUNDS;
            end
         end
         ST_BOUNDS: begin
            if (bounds_bad || bound_count == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:  state_in = ST_MAC;
         ST_MAC: begin
            if (last_chan) begin
               state_in = last_tap ? ST_FINISH : ST_FETCH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = state_ff == ST_IDLE;
   end

   always_comb begin
      source_length_in = source_length_ff;
      dest_length_in   = dest_length_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_LENGTH: source_length_in = csr_data[SRCLEN_W-1:0];
            CSR_DEST_LENGTH:   dest_length_in   = csr_data[DSTLEN_W-1:0];
            default: ;
         endcase
      end

      pos_in   = pos_ff;
      src_in   = src_ff;
      tap_in   = tap_ff;
      count_in = count_ff;
      chan_in  = chan_ff;
      err_in   = err_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         acc_in[c] = acc_ff[c];
      end

      case (state_ff)
         ST_IDLE: begin
            pos_in = req_chan.position[DEST_AW-1:0];
            err_in = compute_bad;
            for (int c = 0; c < CHANNELS; c++) begin
               acc_in[c] = ACC_W'(1) <<< (FRACTION_BITS - 1);
            end
         end
         ST_BOUNDS: begin
            err_in   = bounds_bad;
            src_in   = bound_first[SRC_AW-1:0];
            count_in = bound_count;
            tap_in   = '0;
            chan_in  = '0;
         end
         ST_MAC: begin
            for (int c = 0; c < CHANNELS - 1; c++) begin
               acc_in[c] = acc_ff[c + 1];
            end
            acc_in[CHANNELS-1] = acc_sum;
            if (last_chan) begin
               chan_in = '0;
               tap_in  = tap_ff + COUNT_W'(1);
               src_in  = src_ff + SRC_AW'(1);
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      red_in_r     = red_ff;
      green_in_r   = green_ff;
      blue_in_r    = blue_ff;
      status_in    = status_ff;
      if (finish_now) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            red_in_r   = '0;
            green_in_r = '0;
            blue_in_r  = '0;
            status_in  = STATUS_RANGE;
         end else begin
            red_in_r   = clip_channel(acc_ff[0]);
            green_in_r = clip_channel(acc_ff[1]);
            blue_in_r  = clip_channel(acc_ff[2]);
            status_in  = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         source_length_ff <= SRCLEN_W'(1);
         dest_length_ff   <= DSTLEN_W'(1);
         rsp_valid_ff     <= 1'b0;
         tap_ff           <= '0;
         chan_ff          <= '0;
         err_ff           <= 1'b0;
      end else begin
         state_ff         <= state_in;
         source_length_ff <= source_length_in;
         dest_length_ff   <= dest_length_in;
         rsp_valid_ff     <= rsp_valid_in;
         tap_ff           <= tap_in;
         chan_ff          <= chan_in;
         err_ff           <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      src_ff    <= src_in;
      count_ff  <= count_in;
      red_ff    <= red_in_r;
      green_ff  <= green_in_r;
      blue_ff   <= blue_in_r;
      status_ff <= status_in;
      for (int c = 0; c < CHANNELS; c++) begin
         acc_ff[c] <= acc_in[c];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.red_out   = red_ff;
   assign rsp_chan.green_out = green_ff;
   assign rsp_chan.blue_out  = blue_ff;
   assign rsp_chan.status    = status_ff;

endmodule

`default_nettype wire

FILE: design/sblr_checker.sv
// Port-level assertions for the resampler, attached to the top level by bind.
// Depends on sblr_pkg and on the top level's channel ports.
`default_nettype none

module sblr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [sblr_pkg::MODE_W-1:0]   req_mode,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [sblr_pkg::PIX_W-1:0]    rsp_red,
   input wire logic [sblr_pkg::PIX_W-1:0]    rsp_green,
   input wire logic [sblr_pkg::PIX_W-1:0]    rsp_blue,
   input wire logic                          rsp_status
);
   import sblr_pkg::*;

   logic req_take;
   assign req_take = req_valid && req_ready;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // Load transactions complete at once, so the block stays ready.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_take && req_mode != MODE_COMPUTE |=> req_ready)
      else $error("not ready after a load transaction");

   // A compute transaction leaves the block busy, not ready, once it is taken.
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && req_mode == MODE_COMPUTE |=> !req_ready)
      else $error("ready directly after a compute transaction");

   // A range error carries black colour fields.
   a_error_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_RANGE |->
         rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
      else $error("range error with non-zero colour");

   // Reset clears any pending response.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind separable_bilinear_line_resampler sblr_checker u_sblr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_mode   (req_chan.mode),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_red    (rsp_chan.red_out),
   .rsp_green  (rsp_chan.green_out),
   .rsp_blue   (rsp_chan.blue_out),
   .rsp_status (rsp_chan.status)
);

`default_nettype wire
